// ===== design/rcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants of the rule chain classifier
// Field widths, operation codes, the packed rule word and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

  localparam int CHAIN_W     = 10;
  localparam int ADDR_IN_W   = 13;
  localparam int FIELD_W     = 2;
  localparam int CMP_W       = 2;
  localparam int THR_W       = 16;
  localparam int KIND_W      = 2;
  localparam int VAL_W       = 16;
  localparam int SUM_W       = 18;
  localparam int TOTAL_W     = 48;
  localparam int LIMIT_W     = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // Largest chain index that a register or a rule can name.
  localparam int CHAIN_IDX_MAX = 1023;

  localparam logic [CHAIN_W-1:0] START_CHAIN_RESET = '0;
  localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET  = 16'd4096;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX         = '1;

  localparam logic ACTION_WRITE    = 1'b0;
  localparam logic ACTION_CLASSIFY = 1'b1;

  localparam logic [FIELD_W-1:0] FIELD_X = 2'd0;
  localparam logic [FIELD_W-1:0] FIELD_M = 2'd1;
  localparam logic [FIELD_W-1:0] FIELD_A = 2'd2;
  localparam logic [FIELD_W-1:0] FIELD_S = 2'd3;

  localparam logic [CMP_W-1:0] CMP_ALWAYS  = 2'd0;
  localparam logic [CMP_W-1:0] CMP_LESS    = 2'd1;
  localparam logic [CMP_W-1:0] CMP_GREATER = 2'd2;

  localparam logic [KIND_W-1:0] KIND_JUMP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_CHAIN = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LIMIT  = 1'd1;

  typedef struct packed {
    logic [CHAIN_W-1:0] target;
    logic [KIND_W-1:0]  kind;
    logic [THR_W-1:0]   threshold;
    logic [CMP_W-1:0]   compare;
    logic [FIELD_W-1:0] field;
  } rule_t;

endpackage

`default_nettype wire

// ===== design/rcc_channels.sv =====
// ----------------------------------------------------------------------------
// rcc_channels: handshake channels of the rule chain classifier
// Item, result and configuration channels, each with valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcc_item_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [rcc_pkg::ADDR_IN_W-1:0]   rule_address;
  logic [rcc_pkg::FIELD_W-1:0]     rule_field;
  logic [rcc_pkg::CMP_W-1:0]       rule_compare;
  logic [rcc_pkg::THR_W-1:0]       rule_threshold;
  logic [rcc_pkg::KIND_W-1:0]      rule_target_kind;
  logic [rcc_pkg::CHAIN_W-1:0]     rule_target;
  logic [rcc_pkg::VAL_W-1:0]       item_x;
  logic [rcc_pkg::VAL_W-1:0]       item_m;
  logic [rcc_pkg::VAL_W-1:0]       item_a;
  logic [rcc_pkg::VAL_W-1:0]       item_s;

  modport source (
    output valid, action, rule_address, rule_field, rule_compare, rule_threshold,
    output rule_target_kind, rule_target, item_x, item_m, item_a, item_s,
    input  ready
  );
  modport sink (
    input  valid, action, rule_address, rule_field, rule_compare, rule_threshold,
    input  rule_target_kind, rule_target, item_x, item_m, item_a, item_s,
    output ready
  );
endinterface

interface rcc_result_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [rcc_pkg::SUM_W-1:0]     item_sum;
  logic [rcc_pkg::TOTAL_W-1:0]   accepted_total;
  logic                          walk_error;

  modport source (
    output valid, accepted, item_sum, accepted_total, walk_error,
    input  ready
  );
  modport sink (
    input  valid, accepted, item_sum, accepted_total, walk_error,
    output ready
  );
endinterface

interface rcc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rcc_pkg::CFG_INDEX_W-1:0]  index;
  logic [rcc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/rule_chain_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// rule_chain_classifier_unit: first-match rule chain classifier
// Loads rules into a rule memory and walks chains of them to classify items.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A rule write goes from S_IDLE to S_DONE, where
// its result is loaded into the output register. A classification passes
// through S_REDUCE and S_BASE for each chain entered, including the start
// chain, and through S_FETCH and S_EVAL for each rule examined (at most
// step_limit). S_REDUCE makes MOD_STEPS compare-subtract steps that fold a
// chain index into the CHAINS range (zero for CHAINS of 1024 and up, when
// S_REDUCE is skipped). A walk that runs into the step limit ends in S_FETCH
// with a walk error. S_BASE forms the base address of each chain entered, and
// each examined rule costs one registered read of the rule memory and one
// evaluation in S_EVAL. Results sit in an output register, so the next item
// may be accepted while a result waits; a finished item holds until that
// register is free. Rule memory entries are undefined until written; there is no clearing pass.
`default_nettype none

module rule_chain_classifier_unit #(
  parameter int CHAINS     = 1024,
  parameter int RULE_SLOTS = 8
) (
  input  wire              clk,
  input  wire              rst,
  rcc_item_if.sink         items,
  rcc_result_if.source     results,
  rcc_cfg_if.sink          cfg
);

  localparam int STORE_DEPTH = CHAINS * RULE_SLOTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SLOT_W      = $clog2(RULE_SLOTS);
  localparam int MOD_STEPS   = $clog2(rcc_pkg::CHAIN_IDX_MAX / CHAINS + 1);
  localparam int MOD_SHIFT   = (MOD_STEPS > 0) ? MOD_STEPS - 1 : 0;
  localparam logic [rcc_pkg::CHAIN_W-1:0] MOD_TOP =
    (MOD_STEPS > 0) ? rcc_pkg::CHAIN_W'(CHAINS << MOD_SHIFT) : '0;
  localparam logic [rcc_pkg::CHAIN_W-1:0] MOD_LAST =
    (MOD_STEPS > 0) ? rcc_pkg::CHAIN_W'(CHAINS) : '0;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RULE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_BASE,
    S_FETCH,
    S_EVAL,
    S_DONE
  } state_t;

  state_t                          state;
  logic [rcc_pkg::CHAIN_W-1:0]     start_chain;
  logic [rcc_pkg::LIMIT_W-1:0]     step_limit;
  logic [rcc_pkg::TOTAL_W-1:0]     total;
  logic                            out_valid;
  logic                            out_accepted;
  logic [rcc_pkg::SUM_W-1:0]       out_sum;
  logic                            out_error;

  logic [rcc_pkg::CHAIN_W-1:0]     chain;
  logic [rcc_pkg::CHAIN_W-1:0]     divisor;
  logic [ADDR_W-1:0]               base;
  logic [SLOT_W-1:0]               slot;
  logic [rcc_pkg::LIMIT_W-1:0]     steps;
  logic [rcc_pkg::VAL_W-1:0]       vals [4];
  logic [rcc_pkg::SUM_W-1:0]       sum;
  logic                            acc;
  logic                            err;

  logic [rcc_pkg::CHAIN_W-1:0]     chain_sub;
  logic [ADDR_W-1:0]               rd_addr;
  logic                            store_we;
  rcc_pkg::rule_t                  wr_rule;
  rcc_pkg::rule_t                  rule;
  rcc_pkg::rule_t                  store [STORE_DEPTH];
  logic [rcc_pkg::VAL_W-1:0]       field_val;
  logic                            match;
  logic [rcc_pkg::TOTAL_W:0]       total_wide;
  logic [rcc_pkg::TOTAL_W-1:0]     total_next;
  logic                            item_fire;

  assign item_fire      = items.valid && items.ready;
  assign items.ready    = (state == S_IDLE);
  assign cfg.ready      = (state == S_IDLE);

  assign results.valid          = out_valid;
  assign results.accepted       = out_accepted;
  assign results.item_sum       = out_sum;
  assign results.accepted_total = total;
  assign results.walk_error     = out_error;

  // Rule memory: one write port for rule loads, one registered read port.
  assign wr_rule.target    = items.rule_target;
  assign wr_rule.kind      = items.rule_target_kind;
  assign wr_rule.threshold = items.rule_threshold;
  assign wr_rule.compare   = items.rule_compare;
  assign wr_rule.field     = items.rule_field;
  assign store_we = item_fire && (items.action == rcc_pkg::ACTION_WRITE) &&
                    (32'(items.rule_address) < STORE_DEPTH);
  assign rd_addr  = base + ADDR_W'(slot);

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[ADDR_W'(items.rule_address)] <= wr_rule;
    end
    rule <= store[rd_addr];
  end

  // One restoring compare-subtract step of the chain index fold.
  assign chain_sub = (chain >= divisor) ? chain - divisor : chain;

  assign field_val = vals[rule.field];

  always_comb begin
    case (rule.compare)
      rcc_pkg::CMP_ALWAYS:  match = 1'b1;
      rcc_pkg::CMP_LESS:    match = field_val < rule.threshold;
      rcc_pkg::CMP_GREATER: match = field_val > rule.threshold;
      default:              match = 1'b0;
    endcase
  end

  assign total_wide = {1'b0, total} + (rcc_pkg::TOTAL_W + 1)'(sum);
  assign total_next = !acc ? total :
                      (total_wide[rcc_pkg::TOTAL_W] ? rcc_pkg::TOTAL_MAX
                                                    : total_wide[rcc_pkg::TOTAL_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      start_chain <= rcc_pkg::START_CHAIN_RESET;
      step_limit  <= rcc_pkg::STEP_LIMIT_RESET;
      total       <= '0;
      out_valid   <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (results.valid && results.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          rcc_pkg::CFG_START_CHAIN: start_chain <= cfg.data[rcc_pkg::CHAIN_W-1:0];
          rcc_pkg::CFG_STEP_LIMIT:  step_limit  <= cfg.data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (item_fire) begin
            acc     <= 1'b0;
            err     <= 1'b0;
            vals[0] <= items.item_x;
            vals[1] <= items.item_m;
            vals[2] <= items.item_a;
            vals[3] <= items.item_s;
            chain   <= start_chain;
            divisor <= MOD_TOP;
            steps   <= '0;
            if (items.action == rcc_pkg::ACTION_WRITE) begin
              sum   <= '0;
              state <= S_DONE;
            end else begin
              sum <= rcc_pkg::SUM_W'(items.item_x) + rcc_pkg::SUM_W'(items.item_m) +
                     rcc_pkg::SUM_W'(items.item_a) + rcc_pkg::SUM_W'(items.item_s);
              if (MOD_STEPS == 0) begin
                state <= S_BASE;
              end else begin
                state <= S_REDUCE;
              end
            end
          end
        end

        S_REDUCE: begin
          chain   <= chain_sub;
          divisor <= divisor >> 1;
          if (divisor == MOD_LAST) begin
            state <= S_BASE;
          end
        end

        S_BASE: begin
          base  <= ADDR_W'(chain * RULE_SLOTS);
          slot  <= '0;
          state <= S_FETCH;
        end

        S_FETCH: begin
          // The read of the current slot is issued at this edge.
          if (steps >= step_limit) begin
            err   <= 1'b1;
            state <= S_DONE;
          end else begin
            steps <= steps + 1'b1;
            state <= S_EVAL;
          end
        end

        S_EVAL: begin
          if (match) begin
            case (rule.kind)
              rcc_pkg::KIND_JUMP: begin
                chain   <= rule.target;
                divisor <= MOD_TOP;
                if (MOD_STEPS == 0) begin
                  state <= S_BASE;
                end else begin
                  state <= S_REDUCE;
                end
              end
              rcc_pkg::KIND_ACCEPT: begin
                acc   <= 1'b1;
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end else begin
            slot  <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
            state <= S_FETCH;
          end
        end

        S_DONE: begin
          if (!out_valid || results.ready) begin
            out_valid    <= 1'b1;
            out_accepted <= acc;
            out_sum      <= sum;
            out_error    <= err;
            total        <= total_next;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An item fails the walk or is accepted, never both.
  assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.accepted && results.walk_error))
    else $error("result is both accepted and in error");

  // The running total of accepted sums never goes down.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> total >= $past(total))
    else $error("accepted total decreased");

  // The walk never examines more rules than the step limit allows.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> steps <= step_limit)
    else $error("step count passed the step limit");

  // Only one item is in work at a time.
  assert property (@(posedge clk) disable iff (rst)
    item_fire |=> !items.ready)
    else $error("second item accepted while one is in work");

endmodule

`default_nettype wire
